// ===== hw/rtl/cbm_pkg.sv =====
package cbm_pkg;

    localparam int AMP_W   = 16;
    localparam int IDX_W   = 8;
    localparam int SIN_W   = 16;
    localparam int PROD_W  = 32;
    localparam int COL_W   = 35;
    localparam int WIN_W   = 39;
    localparam int ROW_W   = 16;
    localparam int MAG_W   = 16;
    localparam int PHS_W   = 16;
    localparam int ACC_W   = 34;
    localparam int XY_W    = 34;
    localparam int CORDIC_STEPS = 21;
    localparam int TABLE_SIZE   = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_LINES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LINES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_SCALE    = 3'd5;

    localparam logic [4:0]  RST_LOOK_LINES   = 5'd5;
    localparam logic [4:0]  RST_LOOK_SAMPLES = 5'd1;
    localparam logic [4:0]  RST_STEP_LINES   = 5'd5;
    localparam logic [4:0]  RST_STEP_SAMPLES = 5'd1;
    localparam logic [12:0] RST_LINE_WIDTH   = 13'd1024;
    localparam logic [16:0] RST_AMP_SCALE    = 17'd13107;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WIN,
        ST_ABS,
        ST_KNORM,
        ST_SQA,
        ST_SQB,
        ST_SUM,
        ST_SQRT,
        ST_SCALE,
        ST_SAT,
        ST_PNORM,
        ST_PROT,
        ST_CORD,
        ST_OUT
    } state_t;

    localparam logic [15:0] QUARTER_WAVE [0:64] = '{
        16'd0, 16'd402, 16'd804, 16'd1205, 16'd1606, 16'd2006, 16'd2404, 16'd2801,
        16'd3196, 16'd3590, 16'd3981, 16'd4370, 16'd4756, 16'd5139, 16'd5520,
        16'd5897, 16'd6270, 16'd6640, 16'd7005, 16'd7367, 16'd7724, 16'd8076,
        16'd8423, 16'd8765, 16'd9102, 16'd9434, 16'd9760, 16'd10080, 16'd10394,
        16'd10702, 16'd11003, 16'd11297, 16'd11585, 16'd11866, 16'd12140,
        16'd12406, 16'd12665, 16'd12916, 16'd13160, 16'd13395, 16'd13623,
        16'd13842, 16'd14053, 16'd14256, 16'd14449, 16'd14635, 16'd14811,
        16'd14978, 16'd15137, 16'd15286, 16'd15426, 16'd15557, 16'd15679,
        16'd15791, 16'd15893, 16'd15986, 16'd16069, 16'd16143, 16'd16207,
        16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379, 16'd16384
    };

    function automatic logic signed [SIN_W-1:0] sine_of(input logic [IDX_W-1:0] i);
        logic [6:0]  k;
        logic [15:0] v;
        k = {1'b0, i[5:0]};
        v = i[6] ? QUARTER_WAVE[7'd64 - k] : QUARTER_WAVE[k];
        return i[7] ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic [29:0] atan_step(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004757;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340247;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/cbm_ram.sv =====
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/complex_box_multilook.sv =====
// A pixel is taken only in the idle state; one that completes no box holds the block
// through accept with memory reads, table multiply, column-sum write-back and window.
// A pixel that completes a box then runs the magnitude and phase steps, and the
// input stays stalled until its result is loaded into the output register.
// After reset all LINE_MAX column sums (4096 by default) are cleared while no pixel
// is taken; configuration writes are taken at all times.
module complex_box_multilook #(
    parameter int LOOK_MAX = 16,
    parameter int LINE_MAX = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // amplitude, phase_angle
    input  logic [0:0]                       s_axis_tuser,  // frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // magnitude, phase_out
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import cbm_pkg::*;

    localparam int LKW  = $clog2(LOOK_MAX + 1);
    localparam int SW   = (LOOK_MAX > 1) ? $clog2(LOOK_MAX) : 1;
    localparam int CW   = $clog2(LINE_MAX);
    localparam int WW   = $clog2(LINE_MAX + 1);
    localparam int CMPW = WW + 8;
    localparam int LSD  = LOOK_MAX * LINE_MAX;
    localparam int LSAW = $clog2(LSD);
    localparam logic [LSAW-1:0] LINE_STRIDE = LSAW'(LINE_MAX);

    function automatic logic [LKW-1:0] clamp_look(input logic [4:0] v);
        logic [LKW-1:0] r;
        if (v == 5'd0)
        begin
            r = LKW'(1);
        end
        else if (32'(v) > LOOK_MAX)
        begin
            r = LKW'(LOOK_MAX);
        end
        else
        begin
            r = LKW'(v);
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] back_slot(input logic [SW-1:0] s,
                                                input logic [LKW-1:0] n);
        logic [LKW-1:0] m;
        logic [LKW:0]   t;
        m = (n == LKW'(LOOK_MAX)) ? '0 : n;
        if ((LKW + 1)'(s) >= (LKW + 1)'(m))
        begin
            t = (LKW + 1)'(s) - (LKW + 1)'(m);
        end
        else
        begin
            t = (LKW + 1)'(s) + (LKW + 1)'(LOOK_MAX) - (LKW + 1)'(m);
        end
        return SW'(t);
    endfunction

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(LOOK_MAX - 1)) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [LKW-1:0] mod_byte(input logic [LKW-1:0] rem,
                                                input logic [7:0] byt,
                                                input logic [LKW-1:0] dv);
        logic [LKW:0]   t;
        logic [LKW-1:0] r;
        r = rem;
        for (int j = 7; j >= 0; j--)
        begin
            t = {r, byt[j]};
            if (t >= (LKW + 1)'(dv))
            begin
                t = t - (LKW + 1)'(dv);
            end
            r = t[LKW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_amp(input logic [AMP_W-1:0] a,
                                                         input logic signed [SIN_W-1:0] s);
        logic signed [AMP_W+SIN_W:0] full;
        full = $signed({1'b0, a}) * s;
        return $signed(full[PROD_W-1:0]);
    endfunction

    // Configuration registers.
    logic [4:0]  look_lines_reg, look_samples_reg, step_lines_reg, step_samples_reg;
    logic [12:0] line_width_reg;
    logic [16:0] amp_scale_reg;

    state_t state_reg, state_next;

    // Raster position.
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [SW-1:0]    rslot_reg, cslot_reg;
    logic [CW-1:0]    clr_reg;

    // Per-item registers.
    logic [AMP_W-1:0]              amp_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic signed [SIN_W-1:0]       ncos_reg, nsin_reg;
    logic [LSAW-1:0]               ls_waddr_reg;
    logic [CW-1:0]                 item_col_reg;
    logic [SW-1:0]                 item_cslot_reg, gone_slot_reg;
    logic                          r_zero_reg, r_ge_l_reg, c_zero_reg, c_ge_s_reg;
    logic                          row_ge_reg, col_ge_reg, row_last_reg, out_last_reg;
    logic [15:0]                   rdiff_reg, cdiff_reg;
    logic [LKW-1:0]                sl_reg, ss_reg, rrem_reg, crem_reg;
    logic signed [PROD_W-1:0]      nre_reg, nim_reg, ore_reg, oim_reg;
    logic signed [COL_W-1:0]       cre_reg, cim_reg;

    // Box sums.
    logic signed [WIN_W-1:0]       ws_re_reg, ws_im_reg;
    logic [2*COL_W-1:0]            recent_reg [LOOK_MAX];

    // Magnitude and phase sequencer.
    logic                          re_neg_reg, im_neg_reg;
    logic [WIN_W-1:0]              ma_reg, mb_reg, pa_reg, pb_reg;
    logic [3:0]                    k_reg;
    logic [61:0]                   sqa_reg, sqb_reg;
    logic [63:0]                   n_reg, res_reg, bit_reg;
    logic [56:0]                   scl_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic signed [XY_W-1:0]        x_reg, y_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [4:0]                    i_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [31:0]                   m_data_reg;

    // Memories.
    logic                          ls_we, ls_re, cs_we, cs_re;
    logic [LSAW-1:0]               ls_raddr;
    logic [CW-1:0]                 cs_waddr;
    logic [2*COL_W-1:0]            cs_wdata, cs_rdata;
    logic [AMP_W+IDX_W-1:0]        ls_rdata;

    // Accept-side values.
    logic                          in_xfer, out_load;
    logic [AMP_W-1:0]              in_amp;
    logic [IDX_W-1:0]              in_idx;
    logic [LKW-1:0]                lk_l, lk_s, lk_sl, lk_ss;
    logic [WW-1:0]                 lk_w;
    logic [ROW_W-1:0]              r_cur, r_inc;
    logic [CW-1:0]                 c_cur;
    logic [SW-1:0]                 rs_cur, cs_cur;
    logic                          line_end;

    // Datapath values.
    logic signed [COL_W-1:0]       cs_re_old, cs_im_old, cre_next, cim_next;
    logic signed [COL_W-1:0]       gone_re, gone_im;
    logic signed [WIN_W-1:0]       ws_re_next, ws_im_next;
    logic                          emit;
    logic [AMP_W-1:0]              oamp;
    logic [IDX_W-1:0]              oidx;
    logic [63:0]                   trial;
    logic [39:0]                   m_shift;
    logic [57:0]                   rnd;
    logic [ACC_W-1:0]              acc_rnd;
    logic signed [XY_W-1:0]        dx, dy, px, py;

    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_amp        = s_axis_tdata[15:0];
    assign in_idx        = s_axis_tdata[31:24];
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        lk_l  = clamp_look(look_lines_reg);
        lk_s  = clamp_look(look_samples_reg);
        lk_sl = clamp_look(step_lines_reg);
        lk_ss = clamp_look(step_samples_reg);
        if (line_width_reg == 13'd0)
        begin
            lk_w = WW'(1);
        end
        else if (32'(line_width_reg) > LINE_MAX)
        begin
            lk_w = WW'(LINE_MAX);
        end
        else
        begin
            lk_w = WW'(line_width_reg);
        end
        r_cur    = s_axis_tuser[0] ? '0 : row_reg;
        c_cur    = s_axis_tuser[0] ? '0 : col_reg;
        rs_cur   = s_axis_tuser[0] ? '0 : rslot_reg;
        cs_cur   = s_axis_tuser[0] ? '0 : cslot_reg;
        r_inc    = r_cur + ROW_W'(1);
        line_end = ((WW + 1)'(c_cur) + (WW + 1)'(1)) >= (WW + 1)'(lk_w);
        ls_raddr = LSAW'(back_slot(rs_cur, lk_l)) * LINE_STRIDE + LSAW'(c_cur);
    end

    always_comb
    begin
        cs_re_old = $signed(cs_rdata[COL_W-1:0]);
        cs_im_old = $signed(cs_rdata[2*COL_W-1:COL_W]);
        if (r_zero_reg)
        begin
            cre_next = COL_W'(nre_reg);
            cim_next = COL_W'(nim_reg);
        end
        else
        begin
            cre_next = cs_re_old + COL_W'(nre_reg) - (r_ge_l_reg ? COL_W'(ore_reg) : '0);
            cim_next = cs_im_old + COL_W'(nim_reg) - (r_ge_l_reg ? COL_W'(oim_reg) : '0);
        end
        gone_re = $signed(recent_reg[gone_slot_reg][COL_W-1:0]);
        gone_im = $signed(recent_reg[gone_slot_reg][2*COL_W-1:COL_W]);
        if (c_zero_reg)
        begin
            ws_re_next = WIN_W'(cre_reg);
            ws_im_next = WIN_W'(cim_reg);
        end
        else
        begin
            ws_re_next = ws_re_reg + WIN_W'(cre_reg) - (c_ge_s_reg ? WIN_W'(gone_re) : '0);
            ws_im_next = ws_im_reg + WIN_W'(cim_reg) - (c_ge_s_reg ? WIN_W'(gone_im) : '0);
        end
        emit = row_ge_reg && (rrem_reg == '0) && col_ge_reg && (crem_reg == '0);
        oamp    = ls_rdata[AMP_W+IDX_W-1:IDX_W];
        oidx    = ls_rdata[IDX_W-1:0];
        trial   = res_reg + bit_reg;
        m_shift = 40'(res_reg[31:0]) << k_reg;
        rnd     = 58'(scl_reg) + 58'(1 << 29);
        acc_rnd = acc_reg + ACC_W'(32768);
        dx      = y_reg >>> i_reg;
        dy      = x_reg >>> i_reg;
        px      = re_neg_reg ? -$signed(XY_W'(pa_reg)) : $signed(XY_W'(pa_reg));
        py      = im_neg_reg ? -$signed(XY_W'(pb_reg)) : $signed(XY_W'(pb_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == CW'(LINE_MAX - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_xfer) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_WIN;
            ST_WIN:   state_next = emit ? ST_ABS : ST_IDLE;
            ST_ABS:   state_next = ST_KNORM;
            ST_KNORM: if (ma_reg[WIN_W-1:31] == '0 && mb_reg[WIN_W-1:31] == '0)
                          state_next = ST_SQA;
            ST_SQA:   state_next = ST_SQB;
            ST_SQB:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SQRT;
            ST_SQRT:  if (bit_reg == 64'd1) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_PNORM;
            ST_PNORM:
            begin
                if (pa_reg == '0 && pb_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else if ((pa_reg | pb_reg) < WIN_W'(1 << 30)
                         && (pa_reg | pb_reg) >= WIN_W'(1 << 29))
                begin
                    state_next = ST_PROT;
                end
            end
            ST_PROT:  state_next = ST_CORD;
            ST_CORD:  if (i_reg == 5'(CORDIC_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ls_re         = 1'b0;
        cs_re         = 1'b0;
        ls_we         = 1'b0;
        cs_we         = 1'b0;
        cs_waddr      = item_col_reg;
        cs_wdata      = {cim_next, cre_next};
        unique case (state_reg)
            ST_CLEAR:
            begin
                cs_we    = 1'b1;
                cs_waddr = clr_reg;
                cs_wdata = '0;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ls_re         = s_axis_tvalid;
                cs_re         = s_axis_tvalid;
            end
            ST_ACC:
            begin
                ls_we = 1'b1;
                cs_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    cbm_ram #(
        .WIDTH (AMP_W + IDX_W),
        .DEPTH (LSD)
    ) u_line_store (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr_reg),
        .wdata ({amp_reg, idx_reg}),
        .re    (ls_re),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    cbm_ram #(
        .WIDTH (2 * COL_W),
        .DEPTH (LINE_MAX)
    ) u_column_sums (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (cs_re),
        .raddr (c_cur),
        .rdata (cs_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            look_lines_reg   <= RST_LOOK_LINES;
            look_samples_reg <= RST_LOOK_SAMPLES;
            step_lines_reg   <= RST_STEP_LINES;
            step_samples_reg <= RST_STEP_SAMPLES;
            line_width_reg   <= RST_LINE_WIDTH;
            amp_scale_reg    <= RST_AMP_SCALE;
            row_reg          <= '0;
            col_reg          <= '0;
            rslot_reg        <= '0;
            cslot_reg        <= '0;
            clr_reg          <= '0;
            ws_re_reg        <= '0;
            ws_im_reg        <= '0;
            m_valid_reg      <= 1'b0;
            for (int j = 0; j < LOOK_MAX; j++)
            begin
                recent_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LOOK_LINES:   look_lines_reg   <= cfg_data[4:0];
                    CFG_LOOK_SAMPLES: look_samples_reg <= cfg_data[4:0];
                    CFG_STEP_LINES:   step_lines_reg   <= cfg_data[4:0];
                    CFG_STEP_SAMPLES: step_samples_reg <= cfg_data[4:0];
                    CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[12:0];
                    CFG_AMP_SCALE:    amp_scale_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (in_xfer)
            begin
                if (line_end)
                begin
                    col_reg   <= '0;
                    cslot_reg <= '0;
                    row_reg   <= r_inc;
                    rslot_reg <= (r_inc == '0) ? '0 : next_slot(rs_cur);
                end
                else
                begin
                    col_reg   <= c_cur + CW'(1);
                    cslot_reg <= next_slot(cs_cur);
                    row_reg   <= r_cur;
                    rslot_reg <= rs_cur;
                end
            end
            if (state_reg == ST_WIN)
            begin
                ws_re_reg                  <= ws_re_next;
                ws_im_reg                  <= ws_im_next;
                recent_reg[item_cslot_reg] <= {cim_reg, cre_reg};
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                amp_reg        <= in_amp;
                idx_reg        <= in_idx;
                ncos_reg       <= sine_of(in_idx + IDX_W'(64));
                nsin_reg       <= sine_of(in_idx);
                ls_waddr_reg   <= LSAW'(rs_cur) * LINE_STRIDE + LSAW'(c_cur);
                item_col_reg   <= c_cur;
                item_cslot_reg <= cs_cur;
                gone_slot_reg  <= back_slot(cs_cur, lk_s);
                r_zero_reg     <= (r_cur == '0);
                r_ge_l_reg     <= (r_cur >= ROW_W'(lk_l));
                c_zero_reg     <= (c_cur == '0);
                c_ge_s_reg     <= (CMPW'(c_cur) >= CMPW'(lk_s));
                row_ge_reg     <= ((ROW_W + 1)'(r_cur) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(lk_l);
                rdiff_reg      <= 16'((ROW_W + 1)'(r_cur) + (ROW_W + 1)'(1)
                                      - (ROW_W + 1)'(lk_l));
                col_ge_reg     <= (CMPW'(c_cur) + CMPW'(1)) >= CMPW'(lk_s);
                cdiff_reg      <= 16'(CMPW'(c_cur) + CMPW'(1) - CMPW'(lk_s));
                row_last_reg   <= (CMPW'(c_cur) + CMPW'(lk_ss)) >= CMPW'(lk_w);
                sl_reg         <= lk_sl;
                ss_reg         <= lk_ss;
            end
            ST_MUL:
            begin
                nre_reg  <= mul_amp(amp_reg, ncos_reg);
                nim_reg  <= mul_amp(amp_reg, nsin_reg);
                ore_reg  <= mul_amp(oamp, sine_of(oidx + IDX_W'(64)));
                oim_reg  <= mul_amp(oamp, sine_of(oidx));
                rrem_reg <= mod_byte('0, rdiff_reg[15:8], sl_reg);
                crem_reg <= mod_byte('0, cdiff_reg[15:8], ss_reg);
            end
            ST_ACC:
            begin
                cre_reg  <= cre_next;
                cim_reg  <= cim_next;
                rrem_reg <= mod_byte(rrem_reg, rdiff_reg[7:0], sl_reg);
                crem_reg <= mod_byte(crem_reg, cdiff_reg[7:0], ss_reg);
            end
            ST_ABS:
            begin
                re_neg_reg <= ws_re_reg[WIN_W-1];
                im_neg_reg <= ws_im_reg[WIN_W-1];
                ma_reg     <= ws_re_reg[WIN_W-1] ? WIN_W'(-ws_re_reg) : WIN_W'(ws_re_reg);
                mb_reg     <= ws_im_reg[WIN_W-1] ? WIN_W'(-ws_im_reg) : WIN_W'(ws_im_reg);
                pa_reg     <= ws_re_reg[WIN_W-1] ? WIN_W'(-ws_re_reg) : WIN_W'(ws_re_reg);
                pb_reg     <= ws_im_reg[WIN_W-1] ? WIN_W'(-ws_im_reg) : WIN_W'(ws_im_reg);
                k_reg      <= '0;
            end
            ST_KNORM:
            begin
                if (ma_reg[WIN_W-1:31] != '0 || mb_reg[WIN_W-1:31] != '0)
                begin
                    ma_reg <= ma_reg >> 1;
                    mb_reg <= mb_reg >> 1;
                    k_reg  <= k_reg + 4'd1;
                end
            end
            ST_SQA:
            begin
                sqa_reg <= 62'(ma_reg[30:0]) * 62'(ma_reg[30:0]);
            end
            ST_SQB:
            begin
                sqb_reg <= 62'(mb_reg[30:0]) * 62'(mb_reg[30:0]);
            end
            ST_SUM:
            begin
                n_reg   <= 64'(sqa_reg) + 64'(sqb_reg);
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            ST_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_SCALE:
            begin
                scl_reg <= 57'(m_shift) * 57'(amp_scale_reg);
            end
            ST_SAT:
            begin
                mag_reg <= (rnd[57:30] > 28'd65535) ? 16'hFFFF : rnd[45:30];
            end
            ST_PNORM:
            begin
                if (pa_reg == '0 && pb_reg == '0)
                begin
                    acc_reg <= '0;
                end
                else if ((pa_reg | pb_reg) >= WIN_W'(1 << 30))
                begin
                    pa_reg <= pa_reg >> 1;
                    pb_reg <= pb_reg >> 1;
                end
                else if ((pa_reg | pb_reg) < WIN_W'(1 << 29))
                begin
                    pa_reg <= pa_reg << 1;
                    pb_reg <= pb_reg << 1;
                end
            end
            ST_PROT:
            begin
                i_reg <= '0;
                if (px < 0)
                begin
                    if (py >= 0)
                    begin
                        x_reg   <= py;
                        y_reg   <= -px;
                        acc_reg <= ACC_W'(1 << 30);
                    end
                    else
                    begin
                        x_reg   <= -py;
                        y_reg   <= px;
                        acc_reg <= -$signed(ACC_W'(1 << 30));
                    end
                end
                else
                begin
                    x_reg   <= px;
                    y_reg   <= py;
                    acc_reg <= '0;
                end
            end
            ST_CORD:
            begin
                if (y_reg > 0)
                begin
                    x_reg   <= x_reg + dx;
                    y_reg   <= y_reg - dy;
                    acc_reg <= acc_reg + $signed(ACC_W'(atan_step(i_reg)));
                end
                else
                begin
                    x_reg   <= x_reg - dx;
                    y_reg   <= y_reg + dy;
                    acc_reg <= acc_reg - $signed(ACC_W'(atan_step(i_reg)));
                end
                i_reg <= i_reg + 5'd1;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_data_reg   <= {acc_rnd[31:16], mag_reg};
                    out_last_reg <= row_last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int LOOK_LIM  = 16;
    localparam int LINE_LIM  = 4096;
    localparam int CYCLE_CAP = 3000000;
    localparam int HOLD_LEN  = 3000;

    typedef struct packed {
        logic [MAG_W-1:0]        mag;
        logic signed [PHS_W-1:0] phs;
        logic                    last;
    } look_result_t;

    typedef struct {
        logic [15:0] amp;
        logic [15:0] ang;
        logic        fs;
        logic        known;
        logic        known_last;
    } pixel_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    complex_box_multilook i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Shadow of the block's registers and running state.
    logic [4:0]  sh_look_lines = RST_LOOK_LINES;
    logic [4:0]  sh_look_samples = RST_LOOK_SAMPLES;
    logic [4:0]  sh_step_lines = RST_STEP_LINES;
    logic [4:0]  sh_step_samples = RST_STEP_SAMPLES;
    logic [12:0] sh_line_width = RST_LINE_WIDTH;
    logic [16:0] sh_amp_scale = RST_AMP_SCALE;

    logic [23:0] line_mem [0:LOOK_LIM*LINE_LIM-1];
    longint      col_re [0:LINE_LIM-1];
    longint      col_im [0:LINE_LIM-1];
    longint      hist_re [0:LOOK_LIM-1];
    longint      hist_im [0:LOOK_LIM-1];
    longint      box_re = 0;
    longint      box_im = 0;
    int unsigned cur_row = 0;
    int unsigned cur_col = 0;

    longint angle_step [0:20] = '{
        536870912, 316933406, 167458907, 85004757, 42667331, 21354465, 10679838,
        5340247, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652
    };

    look_result_t pending_q[$];
    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  phases_run = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint table_sine(logic [7:0] i);
        longint v;
        v = i[6] ? longint'(QUARTER_WAVE[7'd64 - {1'b0, i[5:0]}])
                 : longint'(QUARTER_WAVE[{1'b0, i[5:0]}]);
        return i[7] ? -v : v;
    endfunction

    function automatic longint wrap_to(longint v, int bits);
        longint u;
        u = v & ((64'sd1 <<< bits) - 1);
        if (u[bits-1])
            u = u - (64'sd1 <<< bits);
        return u;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] box_magnitude(longint re, longint im);
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        longint unsigned p;
        int k;
        a = (re < 0) ? longint'(-re) : re;
        b = (im < 0) ? longint'(-im) : im;
        k = 0;
        while ((a >> k) >= 64'd2147483648 || (b >> k) >= 64'd2147483648)
            k++;
        m = int_sqrt((a >> k) * (a >> k) + (b >> k) * (b >> k)) << k;
        p = (m * longint'(sh_amp_scale) + (64'd1 << 29)) >> 30;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic logic [15:0] box_phase(longint re, longint im);
        longint unsigned a;
        longint unsigned b;
        longint x;
        longint y;
        longint acc;
        longint t;
        longint dx;
        longint dy;
        longint unsigned r;
        a = (re < 0) ? longint'(-re) : re;
        b = (im < 0) ? longint'(-im) : im;
        acc = 0;
        if (a == 0 && b == 0)
            return 16'd0;
        while ((a | b) >= (64'd1 << 30)) begin
            a = a >> 1;
            b = b >> 1;
        end
        while ((a | b) < (64'd1 << 29)) begin
            a = a << 1;
            b = b << 1;
        end
        x = (re < 0) ? -longint'(a) : longint'(a);
        y = (im < 0) ? -longint'(b) : longint'(b);
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                acc = 64'sd1 <<< 30;
            end
            else begin
                x = -y;
                y = t;
                acc = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + angle_step[i];
            end
            else begin
                x = x - dx;
                y = y + dy;
                acc = acc - angle_step[i];
            end
        end
        r = (longint'(acc) + 32768) >> 16;
        return r[15:0];
    endfunction

    function automatic bit multilook_pixel(logic [15:0] amp, logic [15:0] ang, logic fs,
                                           output look_result_t res);
        int unsigned ll, ls, sl, ss, w, r, c, col, rs, ws, g;
        logic [7:0]  idx;
        logic [23:0] old;
        longint      cre, cim;
        bit          hit;
        ll = clamp_cfg(sh_look_lines, LOOK_LIM);
        ls = clamp_cfg(sh_look_samples, LOOK_LIM);
        sl = clamp_cfg(sh_step_lines, LOOK_LIM);
        ss = clamp_cfg(sh_step_samples, LOOK_LIM);
        w  = clamp_cfg(sh_line_width, LINE_LIM);
        idx = ang[15:8];
        if (fs) begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        col = c % LINE_LIM;
        rs = ((r % LOOK_LIM) + LOOK_LIM - (ll % LOOK_LIM)) % LOOK_LIM;
        ws = r % LOOK_LIM;
        old = line_mem[rs*LINE_LIM + col];
        line_mem[ws*LINE_LIM + col] = {amp, idx};
        cre = longint'(amp) * table_sine(idx + 8'd64);
        cim = longint'(amp) * table_sine(idx);
        if (r != 0) begin
            cre = cre + col_re[col];
            cim = cim + col_im[col];
            if (r >= ll) begin
                cre = cre - longint'(old[23:8]) * table_sine(old[7:0] + 8'd64);
                cim = cim - longint'(old[23:8]) * table_sine(old[7:0]);
            end
        end
        cre = wrap_to(cre, COL_W);
        cim = wrap_to(cim, COL_W);
        col_re[col] = cre;
        col_im[col] = cim;
        g = ((c % LOOK_LIM) + LOOK_LIM - (ls % LOOK_LIM)) % LOOK_LIM;
        if (c == 0) begin
            box_re = cre;
            box_im = cim;
        end
        else begin
            box_re = box_re + cre;
            box_im = box_im + cim;
            if (c >= ls) begin
                box_re = box_re - hist_re[g];
                box_im = box_im - hist_im[g];
            end
        end
        hist_re[c % LOOK_LIM] = cre;
        hist_im[c % LOOK_LIM] = cim;
        box_re = wrap_to(box_re, WIN_W);
        box_im = wrap_to(box_im, WIN_W);
        hit = (r + 1 >= ll) && ((r + 1 - ll) % sl == 0) && (c + 1 >= ls)
              && ((c + 1 - ls) % ss == 0);
        res.mag = box_magnitude(box_re, box_im);
        res.phs = box_phase(box_re, box_im);
        res.last = (c + ss >= w);
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1) & 16'hFFFF;
        end
        else
            cur_col = c + 1;
        return hit;
    endfunction

    task automatic write_regs(logic [4:0] ll, logic [4:0] ls, logic [4:0] sl,
                              logic [4:0] ss, logic [12:0] lw, logic [16:0] sc);
        logic [CFG_DATA_W-1:0] vals [0:5];
        logic [CFG_IDX_W-1:0]  regs [0:5];
        regs = '{CFG_LOOK_LINES, CFG_LOOK_SAMPLES, CFG_STEP_LINES, CFG_STEP_SAMPLES,
                 CFG_LINE_WIDTH, CFG_AMP_SCALE};
        vals = '{17'(ll), 17'(ls), 17'(sl), 17'(ss), 17'(lw), sc};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        sh_look_lines = ll;
        sh_look_samples = ls;
        sh_step_lines = sl;
        sh_step_samples = ss;
        sh_line_width = lw;
        sh_amp_scale = sc;
        phases_run++;
    endtask

    task automatic send_pixel(logic [15:0] amp, logic [15:0] ang, logic fs, bit known,
                              logic known_last);
        look_result_t res;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ang, amp};
        s_axis_tuser <= fs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (multilook_pixel(amp, ang, fs, res)) begin
            if (known) begin
                res.mag = '0;
                res.phs = '0;
                res.last = known_last;
            end
            pending_q.push_back(res);
        end
        items_sent++;
        if (items_sent == 900)
            hold_req = 1'b1;
        if (items_sent > 1500)
            idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_look();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 5'd0;
        if (r == 1)
            return 5'($urandom_range(17, 31));
        if (r < 12)
            return 5'($urandom_range(1, 4));
        return 5'($urandom_range(1, 16));
    endfunction

    function automatic logic [15:0] pick_amp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'hFFFF;
        if (r == 1)
            return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic send_frame(int unsigned rows, int unsigned w);
        for (int unsigned i = 0; i < rows * w; i++)
            send_pixel(pick_amp(), 16'($urandom), (i == 0) || ($urandom_range(0, 39) == 0),
                       1'b0, 1'b0);
    endtask

    pixel_row_t opening [0:17] = '{
        '{16'd0,     16'h1234, 1'b1, 1'b1, 1'b0},
        '{16'd65535, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h4000, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'hC000, 1'b0, 1'b0, 1'b0},
        '{16'd1,     16'hFFFF, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h00FF, 1'b0, 1'b0, 1'b0},
        '{16'd0,     16'hFFFF, 1'b0, 1'b1, 1'b1},
        '{16'd40000, 16'h2000, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h7F00, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h8100, 1'b0, 1'b0, 1'b0},
        '{16'd12345, 16'hE000, 1'b0, 1'b0, 1'b0},
        '{16'd0,     16'h5555, 1'b1, 1'b1, 1'b0},
        '{16'd32768, 16'hAAAA, 1'b0, 1'b0, 1'b0},
        '{16'd1,     16'h0100, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'hFF00, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{16'd65535, 16'h0000, 1'b0, 1'b0, 1'b0}
    };

    initial begin
        for (int i = 0; i < LOOK_LIM*LINE_LIM; i++)
            line_mem[i] = '0;
        for (int i = 0; i < LINE_LIM; i++) begin
            col_re[i] = 0;
            col_im[i] = 0;
        end
        for (int i = 0; i < LOOK_LIM; i++) begin
            hist_re[i] = 0;
            hist_im[i] = 0;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout at %0t with %0d results pending", $realtime, pending_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : result_side
        look_result_t want;
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, actual mag=%0d phs=%0d last=%0b",
                             $realtime, m_axis_tdata[15:0], $signed(m_axis_tdata[31:16]),
                             m_axis_tlast);
                end
                else begin
                    want = pending_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.mag) begin
                        errors++;
                        $display("%0t: magnitude expected %0d actual %0d", $realtime,
                                 want.mag, m_axis_tdata[15:0]);
                    end
                    if (m_axis_tdata[31:16] !== want.phs) begin
                        errors++;
                        $display("%0t: phase expected %0d actual %0d", $realtime,
                                 want.phs, $signed(m_axis_tdata[31:16]));
                    end
                    if (m_axis_tlast !== want.last) begin
                        errors++;
                        $display("%0t: row_last expected %0b actual %0b", $realtime,
                                 want.last, m_axis_tlast);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [4:0]  ll, ls, sl, ss;
        logic [12:0] lw;
        logic [16:0] sc;
        int unsigned w, rows, fit;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(5'd1, 5'd1, 5'd1, 5'd1, 13'd4, 17'd65536);
        foreach (opening[i])
            send_pixel(opening[i].amp, opening[i].ang, opening[i].fs, opening[i].known,
                       opening[i].known_last);
        drain_block();

        // Full box of maximal phasors with the highest gain drives the magnitude into saturation.
        write_regs(5'd16, 5'd16, 5'd16, 5'd16, 13'd16, 17'd131071);
        for (int i = 0; i < 256; i++)
            send_pixel(16'hFFFF, 16'h0000, i == 0, 1'b0, 1'b0);
        drain_block();

        write_regs(5'd1, 5'd1, 5'd0, 5'd0, 13'd0, 17'd0);
        send_frame(12, 1);
        drain_block();

        write_regs(5'd31, 5'd1, 5'd1, 5'd1, 13'd8191, 17'd65536);
        for (int i = 0; i < 40; i++)
            send_pixel(pick_amp(), 16'($urandom), i == 0, 1'b0, 1'b0);
        drain_block();

        while (items_sent < 1700) begin
            ll = pick_look();
            ls = pick_look();
            sl = pick_look();
            ss = pick_look();
            w = clamp_cfg(ls, LOOK_LIM) + $urandom_range(0, 8);
            lw = 13'(w);
            case ($urandom_range(0, 5))
                0: sc = 17'd0;
                1: sc = 17'd65536;
                2: sc = 17'd131071;
                default: sc = 17'($urandom_range(0, 131071));
            endcase
            write_regs(ll, ls, sl, ss, lw, sc);
            rows = clamp_cfg(ll, LOOK_LIM) + $urandom_range(0, 2 * clamp_cfg(sl, LOOK_LIM));
            fit = 400 / w;
            if (rows > fit)
                rows = fit;
            send_frame(rows, w);
            drain_block();
        end

        repeat (120) @(posedge clk);
        $display("Covered %0d pixels over %0d register settings, %0d boxes checked.",
                 items_sent, phases_run, results_seen);
        $display("Included saturation, clamped registers, mid-frame restarts and a long hold.");
        if (errors == 0 && pending_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_ram.sv
hw/rtl/complex_box_multilook.sv
bench/tb_top.sv
